>>> hw/rtl/kcct_pkg.sv
// Package for the k-mer case/control table: field widths, result codes,
// default sizes and the entry classifier. Depends on nothing.
package kcct_pkg;

    localparam int KMER_W  = 46;
    localparam int COUNT_W = 32;
    localparam int BIDX_W  = 10;
    localparam int CODE_W  = 3;

    // One stored entry: valid, k-mer, case count, control count.
    localparam int ENTRY_W = 1 + KMER_W + 2 * COUNT_W;

    localparam int DEF_BUCKETS    = 1024;
    localparam int DEF_WAYS       = 8;
    localparam int DEF_KMER_BASES = 23;

    // Result kinds.
    localparam logic [CODE_W-1:0] KIND_UPDATED = 3'd0;
    localparam logic [CODE_W-1:0] KIND_NEW     = 3'd1;
    localparam logic [CODE_W-1:0] KIND_FULL    = 3'd2;
    localparam logic [CODE_W-1:0] KIND_DUMPED  = 3'd3;
    localparam logic [CODE_W-1:0] KIND_EMPTY   = 3'd4;

    // Entry classes reported by a dump.
    localparam logic [CODE_W-1:0] CAT_PRES_ABS     = 3'd0;
    localparam logic [CODE_W-1:0] CAT_MULT_SINGLE  = 3'd1;
    localparam logic [CODE_W-1:0] CAT_REF_PRES_ABS = 3'd2;
    localparam logic [CODE_W-1:0] CAT_REF_MULT_SGL = 3'd3;
    localparam logic [CODE_W-1:0] CAT_NONE         = 3'd4;

    // Sort an entry into one of the four classes, or CAT_NONE when no rule applies; first rule wins.
    function automatic logic [CODE_W-1:0] classify(input logic [COUNT_W-1:0] cs,
                                                   input logic [COUNT_W-1:0] ct);
        logic [CODE_W-1:0] c;
        if (cs != '0 && ct == '0)
            c = CAT_PRES_ABS;
        else if (cs > COUNT_W'(1) && ct == COUNT_W'(1))
            c = CAT_MULT_SINGLE;
        else if (cs == '0 && ct != '0)
            c = CAT_REF_PRES_ABS;
        else if (cs == COUNT_W'(1) && ct > COUNT_W'(1))
            c = CAT_REF_MULT_SGL;
        else
            c = CAT_NONE;
        return c;
    endfunction

endpackage

>>> hw/rtl/kmer_case_control_table.sv
// Top level of the k-mer case/control table: bucket memory, sequencer and
// result register. Depends on kcct_pkg.
//
//  channel  | handshake              | fields
//  ---------+------------------------+-----------------------------------------------
//  command  | start, busy            | action, kmer_code, count, is_case, bucket_index
//  result   | result_valid (strobe)  | kind, category, out_kmer, case_count,
//           |                        | control_count, last
//
// A word is taken when start is high and busy is low. An insert reads the bucket
// row, then compares all ways and writes back, when BUCKETS is a power of two;
// otherwise a three-step remainder and a row read come before the compare.
// A dump reads the bucket row, then walks its ways when it reports entries.
// After reset a clearing pass over all BUCKETS rows, one row a cycle, holds busy high.
// Results are strobed for one cycle; the receiver cannot stall them.
module kmer_case_control_table #(
    parameter int BUCKETS    = kcct_pkg::DEF_BUCKETS,
    parameter int WAYS       = kcct_pkg::DEF_WAYS,
    parameter int KMER_BASES = kcct_pkg::DEF_KMER_BASES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [kcct_pkg::KMER_W-1:0]  kmer_code,
    input  logic [kcct_pkg::COUNT_W-1:0] count,
    input  logic                         is_case,
    input  logic [kcct_pkg::BIDX_W-1:0]  bucket_index,
    output logic                         result_valid,
    output logic [kcct_pkg::CODE_W-1:0]  kind,
    output logic [kcct_pkg::CODE_W-1:0]  category,
    output logic [kcct_pkg::KMER_W-1:0]  out_kmer,
    output logic [kcct_pkg::COUNT_W-1:0] case_count,
    output logic [kcct_pkg::COUNT_W-1:0] control_count,
    output logic                         last
);
    import kcct_pkg::*;

    localparam int ABW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KW     = 2 * KMER_BASES;
    localparam int KEFF   = (KW < KMER_W) ? KW : KMER_W;
    localparam int ROW_W  = WAYS * ENTRY_W;
    localparam bit POW2   = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam logic [KMER_W-1:0] KMASK = {KMER_W{1'b1}} >> (KMER_W - KEFF);
    localparam int NBYTES = (KMER_W + 7) / 8;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

    // Weight of each k-mer byte in the bucket remainder: 2^(8k) mod BUCKETS.
    function automatic logic [NBYTES*32-1:0] byte_weights();
        logic [NBYTES*32-1:0] wt;
        logic [63:0]          w;
        wt = '0;
        w  = 64'd1;
        for (int k = 0; k < NBYTES; k++)
        begin
            wt[k*32 +: 32] = w[31:0];
            w = (w << 8) % 64'(BUCKETS);
        end
        return wt;
    endfunction

    localparam logic [NBYTES*32-1:0] BYTE_WT = byte_weights();

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_MOD, S_QUOT, S_REM, S_RD, S_EVAL,
                              S_DUMP} state_t;

    state_t                 state_reg;
    logic [ABW-1:0]         clr_reg;
    logic [ABW-1:0]         addr_reg;
    logic                   action_reg;
    logic [KMER_W-1:0]      kmer_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   is_case_reg;
    logic                   oor_reg;
    logic [31:0]            sum_reg;
    logic [31:0]            quot_reg;
    logic [WW-1:0]          way_reg;
    logic                   res_valid_reg;
    logic [CODE_W-1:0]      res_kind_reg;
    logic [CODE_W-1:0]      res_cat_reg;
    logic [KMER_W-1:0]      res_kmer_reg;
    logic [COUNT_W-1:0]     res_case_reg;
    logic [COUNT_W-1:0]     res_ctrl_reg;
    logic                   res_last_reg;

    // Bucket memory: one row holds all ways of a bucket.
    logic [ROW_W-1:0]       mem [BUCKETS];
    logic [ROW_W-1:0]       rd_data_reg;
    logic                   rd_en;
    logic [ABW-1:0]         rd_addr;
    logic                   wr_en;
    logic [ABW-1:0]         wr_addr;
    logic [ROW_W-1:0]       wr_data;

    logic [KMER_W-1:0]      kmer_in;
    logic [KMER_W+ABW-1:0]  kmer_wide;
    logic [ABW+BIDX_W-1:0]  bidx_wide;
    logic [ABW-1:0]         in_bucket;
    logic [ABW-1:0]         dump_bucket;
    logic                   oor_in;
    logic [NBYTES*8-1:0]    kmer_pad;
    logic [31:0]            byte_sum;
    logic [63:0]            quot_full;
    logic [31:0]            rem_full;
    logic [31:0]            rem_fix;

    logic [WAYS-1:0]        vld;
    logic [WAYS-1:0]        hit;
    logic [WAYS-1:0]        rep;
    logic [WW-1:0]          hit_idx;
    logic [WW-1:0]          free_idx;
    logic [WW-1:0]          sel;
    logic                   any_hit;
    logic                   any_free;
    logic [ENTRY_W-1:0]     old_ent;
    logic [ENTRY_W-1:0]     new_ent;
    logic [ROW_W-1:0]       upd_row;
    logic [ENTRY_W-1:0]     cur_ent;
    logic                   higher;
    logic [ENTRY_W-1:0]     ent;

    // Input word decoding.
    assign kmer_in     = kmer_code & KMASK;
    assign kmer_wide   = (KMER_W + ABW)'(kmer_in);
    assign in_bucket   = kmer_wide[ABW-1:0];
    assign bidx_wide   = (ABW + BIDX_W)'(bucket_index);
    assign dump_bucket = bidx_wide[ABW-1:0];
    assign oor_in      = bidx_wide >= (ABW + BIDX_W)'(BUCKETS);

    // Bucket remainder for other sizes: weighted byte sum, then a reciprocal
    // quotient estimate, then one correcting subtract.
    assign kmer_pad = (NBYTES * 8)'(kmer_reg);

    always_comb
    begin
        byte_sum = '0;
        for (int k = 0; k < NBYTES; k++)
            byte_sum = byte_sum + 32'(kmer_pad[k*8 +: 8]) * BYTE_WT[k*32 +: 32];
    end

    assign quot_full = 64'(sum_reg) * 64'(RECIP);
    assign rem_full  = sum_reg - quot_reg * 32'(BUCKETS);
    assign rem_fix   = (rem_full >= 32'(BUCKETS)) ? rem_full - 32'(BUCKETS) : rem_full;

    // Compare all ways of the row just read.
    always_comb
    begin
        ent = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            ent    = rd_data_reg[w*ENTRY_W +: ENTRY_W];
            vld[w] = ent[ENTRY_W-1];
            hit[w] = ent[ENTRY_W-1] && (ent[ENTRY_W-2 -: KMER_W] == kmer_reg);
            rep[w] = ent[ENTRY_W-1] &&
                     (classify(ent[2*COUNT_W-1:COUNT_W], ent[COUNT_W-1:0]) != CAT_NONE);
        end
    end

    // Lowest matching way and lowest free way.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit[w])
                hit_idx = WW'(w);
            if (!vld[w])
                free_idx = WW'(w);
        end
    end

    assign any_hit  = |hit;
    assign any_free = ~&vld;
    assign sel      = any_hit ? hit_idx : free_idx;
    assign old_ent  = rd_data_reg[sel*ENTRY_W +: ENTRY_W];

    // Updated entry and row for an insert.
    always_comb
    begin
        new_ent = {1'b1, kmer_reg,
                   is_case_reg ? count_reg : (any_hit ? old_ent[2*COUNT_W-1:COUNT_W] : '0),
                   is_case_reg ? (any_hit ? old_ent[COUNT_W-1:0] : '0) : count_reg};
        upd_row = rd_data_reg;
        upd_row[sel*ENTRY_W +: ENTRY_W] = new_ent;
    end

    // Dump walk: current way and whether a later way still reports.
    assign cur_ent = rd_data_reg[way_reg*ENTRY_W +: ENTRY_W];
    assign higher  = ((rep >> way_reg) >> 1) != '0;

    // Memory port control.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = addr_reg;
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        unique case (state_reg)
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
            end
            S_IDLE:
            begin
                rd_en   = start;
                rd_addr = action ? dump_bucket : in_bucket;
            end
            S_RD:
                rd_en = 1'b1;
            S_EVAL:
            begin
                if (!action_reg)
                begin
                    wr_en   = any_hit || any_free;
                    wr_data = upd_row;
                end
                else
                    wr_en = !oor_reg;
            end
            S_MOD, S_QUOT, S_REM, S_DUMP:
                rd_en = 1'b0;
            default:
                rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ABW'(BUCKETS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        action_reg  <= action;
                        kmer_reg    <= kmer_in;
                        count_reg   <= count;
                        is_case_reg <= is_case;
                        oor_reg     <= oor_in;
                        if (action)
                        begin
                            addr_reg  <= dump_bucket;
                            state_reg <= S_EVAL;
                        end
                        else if (POW2)
                        begin
                            addr_reg  <= in_bucket;
                            state_reg <= S_EVAL;
                        end
                        else
                            state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    sum_reg   <= byte_sum;
                    state_reg <= S_QUOT;
                end
                S_QUOT:
                begin
                    quot_reg  <= quot_full[63:32];
                    state_reg <= S_REM;
                end
                S_REM:
                begin
                    addr_reg  <= rem_fix[ABW-1:0];
                    state_reg <= S_RD;
                end
                S_RD:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    res_cat_reg  <= CAT_NONE;
                    res_last_reg <= 1'b1;
                    if (!action_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        res_kmer_reg  <= kmer_reg;
                        state_reg     <= S_IDLE;
                        if (any_hit || any_free)
                        begin
                            res_kind_reg <= any_hit ? KIND_UPDATED : KIND_NEW;
                            res_case_reg <= new_ent[2*COUNT_W-1:COUNT_W];
                            res_ctrl_reg <= new_ent[COUNT_W-1:0];
                        end
                        else
                        begin
                            res_kind_reg <= KIND_FULL;
                            res_case_reg <= '0;
                            res_ctrl_reg <= '0;
                        end
                    end
                    else if (oor_reg || rep == '0)
                    begin
                        res_valid_reg <= 1'b1;
                        res_kind_reg  <= KIND_EMPTY;
                        res_kmer_reg  <= '0;
                        res_case_reg  <= '0;
                        res_ctrl_reg  <= '0;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        way_reg   <= '0;
                        state_reg <= S_DUMP;
                    end
                end
                S_DUMP:
                begin
                    way_reg <= way_reg + 1'b1;
                    if (rep[way_reg])
                    begin
                        res_valid_reg <= 1'b1;
                        res_kind_reg  <= KIND_DUMPED;
                        res_cat_reg   <= classify(cur_ent[2*COUNT_W-1:COUNT_W],
                                                  cur_ent[COUNT_W-1:0]);
                        res_kmer_reg  <= cur_ent[ENTRY_W-2 -: KMER_W];
                        res_case_reg  <= cur_ent[2*COUNT_W-1:COUNT_W];
                        res_ctrl_reg  <= cur_ent[COUNT_W-1:0];
                        res_last_reg  <= !higher;
                        if (!higher)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = res_valid_reg;
    assign kind          = res_kind_reg;
    assign category      = res_cat_reg;
    assign out_kmer      = res_kmer_reg;
    assign case_count    = res_case_reg;
    assign control_count = res_ctrl_reg;
    assign last          = res_last_reg;

    // A word is never answered in the cycle right after it is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result in the cycle after acceptance");

    // More results of the same word follow, so the block stays busy.
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final result while idle");

    // Only dumped entries carry a class.
    a_cat_dump: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((kind == KIND_DUMPED) == (category != CAT_NONE)))
        else $error("category does not match kind");

endmodule
